// ===== sv/pfms_pkg.sv =====
`timescale 1ns / 1ps

package pfms_pkg;

    // sizes of the pattern store and the text window
    localparam int PATTERN_MAX = 64;
    localparam int IDX_W       = $clog2(PATTERN_MAX);
    localparam int BYTE_W      = 8;

    // pattern length register and position counter
    localparam int LEN_W    = 7;
    localparam int CNT_W    = 21;
    localparam int TEXT_MAX = 1048576;

    // request codes on the input channel
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TEXT = 1'b1;

    // one byte lane per pattern position, entry 0 in the low bits
    typedef logic [PATTERN_MAX-1:0][BYTE_W-1:0] byte_vec_t;

endpackage

// ===== sv/pfms_in_if.sv =====
`timescale 1ns / 1ps

interface pfms_in_if;

    logic                        valid;
    logic                        ready;
    logic                        req_type;
    logic [pfms_pkg::BYTE_W-1:0] data_byte;
    logic [pfms_pkg::IDX_W-1:0]  pattern_index;
    logic                        last_byte;

    modport source (
        output valid,
        output req_type,
        output data_byte,
        output pattern_index,
        output last_byte,
        input  ready
    );

    modport sink (
        input  valid,
        input  req_type,
        input  data_byte,
        input  pattern_index,
        input  last_byte,
        output ready
    );

endinterface

// ===== sv/pfms_out_if.sv =====
`timescale 1ns / 1ps

interface pfms_out_if;

    logic                       valid;
    logic                       ready;
    logic                       found;
    logic [pfms_pkg::CNT_W-1:0] match_start;

    modport source (
        output valid,
        output found,
        output match_start,
        input  ready
    );

    modport sink (
        input  valid,
        input  found,
        input  match_start,
        output ready
    );

endinterface

// ===== sv/pfms_window_cmp.sv =====
`timescale 1ns / 1ps

module pfms_window_cmp (
    input  pfms_pkg::byte_vec_t              window,
    input  pfms_pkg::byte_vec_t              pattern,
    input  logic [pfms_pkg::LEN_W-1:0]       len,
    output logic                             match
);

    localparam int PM     = pfms_pkg::PATTERN_MAX;
    localparam int LEN_W  = pfms_pkg::LEN_W;
    localparam int SH_W   = LEN_W + 3;

    pfms_pkg::byte_vec_t    win_rev;
    pfms_pkg::byte_vec_t    aligned;
    logic [LEN_W-1:0]       gap;
    logic [SH_W-1:0]        shamt;
    logic [PM-1:0]          lane_ok;

    // reverse the window so the newest byte sits at the top
    always_comb
    begin
        for (int m = 0; m < PM; m++)
        begin
            win_rev[m] = window[PM-1-m];
        end
    end

    // align window byte len-1-j onto pattern lane j
    assign gap     = LEN_W'(PM) - len;
    assign shamt   = {gap, 3'b000};
    assign aligned = win_rev >> shamt;

    // per-lane compare, lanes at or above len always pass
    always_comb
    begin
        for (int j = 0; j < PM; j++)
        begin
            lane_ok[j] = (LEN_W'(j) >= len) || (aligned[j] == pattern[j]);
        end
    end

    assign match = &lane_ok;

endmodule

// ===== sv/pattern_first_match_search.sv =====
`timescale 1ns / 1ps

// Exact pattern search over a byte stream. Load words write one pattern byte
// into the store at pattern_index; text words shift one byte into a window of
// the latest PATTERN_MAX bytes, and the window is compared against the first
// pattern_length pattern bytes. The first full match of a text returns found=1
// and the 1-based start position; a text that ends (last_byte) without a match
// returns found=0 and match_start=0. Any word is taken every cycle unless a word
// that gives a result waits behind a stalled result. Each word is registered in
// the input register, and the window compare on it feeds the result register. A
// stalled result holds the result register, and one more word can wait in the
// input register; words that give no result keep moving past a stalled result.
// The user must write pattern_length through cfg_wen/cfg_wdata between texts;
// the block itself does not enforce this.
module pattern_first_match_search (
    input  logic                          clk,
    input  logic                          rst_n,
    pfms_in_if.sink                       byte_stream,
    pfms_out_if.source                    match_result,
    input  logic                          cfg_wen,
    input  logic [pfms_pkg::LEN_W-1:0]    cfg_wdata
);

    localparam int PM     = pfms_pkg::PATTERN_MAX;
    localparam int BYTE_W = pfms_pkg::BYTE_W;
    localparam int IDX_W  = pfms_pkg::IDX_W;
    localparam int LEN_W  = pfms_pkg::LEN_W;
    localparam int CNT_W  = pfms_pkg::CNT_W;

    // input register
    logic                   in_valid_reg;
    logic                   in_req_reg;
    logic [BYTE_W-1:0]      in_byte_reg;
    logic [IDX_W-1:0]       in_idx_reg;
    logic                   in_last_reg;

    // block state
    logic [LEN_W-1:0]       len_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic                   done_reg;
    logic                   done_next;
    pfms_pkg::byte_vec_t    window_reg;
    pfms_pkg::byte_vec_t    window_next;
    pfms_pkg::byte_vec_t    pattern_reg;

    // result register
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   out_found_reg;
    logic [CNT_W-1:0]       out_start_reg;

    logic                   in_take;
    logic                   advance;
    logic                   is_text;
    logic [LEN_W-1:0]       len_use;
    logic [CNT_W-1:0]       count_inc;
    logic                   full_eq;
    logic                   hit;
    logic                   emit;
    logic [CNT_W-1:0]       start_pos;

    // handshake: the input register refills as soon as its word moves on
    assign in_take           = byte_stream.valid && byte_stream.ready;
    assign byte_stream.ready = !in_valid_reg || advance;
    assign advance           = in_valid_reg && (!emit || !out_valid_reg || match_result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (byte_stream.ready)
        begin
            in_valid_reg <= byte_stream.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_req_reg  <= byte_stream.req_type;
            in_byte_reg <= byte_stream.data_byte;
            in_idx_reg  <= byte_stream.pattern_index;
            in_last_reg <= byte_stream.last_byte;
        end
    end

    // effective length, clamped to 1..PATTERN_MAX
    always_comb
    begin
        if (len_reg == '0)
        begin
            len_use = LEN_W'(1);
        end
        else if (len_reg > LEN_W'(PM))
        begin
            len_use = LEN_W'(PM);
        end
        else
        begin
            len_use = len_reg;
        end
    end

    // window shift, newest byte in entry 0
    assign window_next = {window_reg[PM-2:0], in_byte_reg};

    // saturating position count
    assign count_inc = (count_reg < CNT_W'(pfms_pkg::TEXT_MAX)) ? count_reg + CNT_W'(1)
                                                               : count_reg;

    pfms_window_cmp u_cmp (
        .window  (window_next),
        .pattern (pattern_reg),
        .len     (len_use),
        .match   (full_eq)
    );

    // match and result decision for the word in the input register
    assign is_text   = (in_req_reg == pfms_pkg::REQ_TEXT);
    assign hit       = is_text && !done_reg && (count_inc >= CNT_W'(len_use)) && full_eq;
    assign emit      = hit || (is_text && in_last_reg && !done_reg);
    assign start_pos = hit ? (count_inc - CNT_W'(len_use) + CNT_W'(1)) : '0;

    // per-text state, cleared by the last byte
    always_comb
    begin
        count_next = count_reg;
        done_next  = done_reg;
        if (advance && is_text)
        begin
            if (in_last_reg)
            begin
                count_next = '0;
                done_next  = 1'b0;
            end
            else
            begin
                count_next = count_inc;
                done_next  = done_reg || hit;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
            len_reg   <= LEN_W'(1);
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
            if (cfg_wen)
            begin
                len_reg <= cfg_wdata;
            end
        end
    end

    // window and pattern store
    always_ff @(posedge clk)
    begin
        if (advance && is_text)
        begin
            window_reg <= window_next;
        end
        if (advance && !is_text)
        begin
            pattern_reg[in_idx_reg] <= in_byte_reg;
        end
    end

    // result register
    always_comb
    begin
        if (advance && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (match_result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_found_reg <= hit;
            out_start_reg <= start_pos;
        end
    end

    assign match_result.valid       = out_valid_reg;
    assign match_result.found       = out_found_reg;
    assign match_result.match_start = out_start_reg;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int PATTERN_MAX = pfms_pkg::PATTERN_MAX;
    localparam int TEXT_MAX    = pfms_pkg::TEXT_MAX;
    localparam int BYTE_W      = pfms_pkg::BYTE_W;
    localparam int IDX_W       = pfms_pkg::IDX_W;
    localparam int LEN_W       = pfms_pkg::LEN_W;
    localparam int CNT_W       = pfms_pkg::CNT_W;

    // cycles the block may still need after its last result, and the watchdog
    localparam int SETTLE_CYCLES = 6;
    localparam int STALL_LIMIT   = 5000;
    localparam int PHASE_WORDS   = 100;
    localparam int PHASES        = 8;

    typedef enum logic [1:0] {
        ROW_LOAD,
        ROW_TEXT,
        ROW_CFG
    } row_kind_t;

    // one directed row; a cfg row carries the length in b
    typedef struct packed {
        row_kind_t         kind;
        logic [BYTE_W-1:0] b;
        logic [IDX_W-1:0]  ix;
        logic              lst;
        logic              typed;
        logic              tf;
        logic [CNT_W-1:0]  ts;
    } dir_row_t;

    typedef struct packed {
        logic             found;
        logic [CNT_W-1:0] start;
    } match_res_t;

    logic clk;
    logic rst_n;
    logic cfg_wen;
    logic [LEN_W-1:0] cfg_wdata;
    logic take_ok = 1'b0;

    pfms_in_if  in_if ();
    pfms_out_if out_if ();

    assign out_if.ready = take_ok;

    pattern_first_match_search dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_stream  (in_if),
        .match_result (out_if),
        .cfg_wen      (cfg_wen),
        .cfg_wdata    (cfg_wdata)
    );

    // search state kept alongside the block
    logic [BYTE_W-1:0] pat_store [PATTERN_MAX];
    logic [BYTE_W-1:0] win [PATTERN_MAX];
    logic [CNT_W-1:0]  txt_count;
    bit                hit_done;
    logic [LEN_W-1:0]  len_reg;

    match_res_t pending_results [$];
    logic [BYTE_W-1:0] letters [3];

    int fail_count = 0;
    int words_taken = 0;
    int idle_cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    // directed words: extremes, suppression, short text, the zero-length clamp
    dir_row_t dir_tab [23] = '{
        '{ROW_LOAD, 8'h00, 6'd0,  1'b0, 1'b0, 1'b0, 21'd0},
        '{ROW_TEXT, 8'h00, 6'd0,  1'b0, 1'b1, 1'b1, 21'd1},
        '{ROW_TEXT, 8'h00, 6'd0,  1'b1, 1'b0, 1'b0, 21'd0},
        '{ROW_TEXT, 8'hff, 6'd63, 1'b1, 1'b1, 1'b0, 21'd0},
        '{ROW_LOAD, 8'hff, 6'd0,  1'b1, 1'b0, 1'b0, 21'd0},
        '{ROW_LOAD, 8'h5a, 6'd63, 1'b0, 1'b0, 1'b0, 21'd0},
        '{ROW_TEXT, 8'hff, 6'd0,  1'b1, 1'b1, 1'b1, 21'd1},
        '{ROW_TEXT, 8'h01, 6'd0,  1'b0, 1'b0, 1'b0, 21'd0},
        '{ROW_TEXT, 8'h02, 6'd0,  1'b0, 1'b0, 1'b0, 21'd0},
        '{ROW_TEXT, 8'hff, 6'd0,  1'b0, 1'b1, 1'b1, 21'd3},
        '{ROW_TEXT, 8'hff, 6'd0,  1'b0, 1'b0, 1'b0, 21'd0},
        '{ROW_TEXT, 8'h00, 6'd0,  1'b1, 1'b0, 1'b0, 21'd0},
        '{ROW_CFG,  8'd3,  6'd0,  1'b0, 1'b0, 1'b0, 21'd0},
        '{ROW_LOAD, 8'h61, 6'd0,  1'b0, 1'b0, 1'b0, 21'd0},
        '{ROW_LOAD, 8'h62, 6'd1,  1'b0, 1'b0, 1'b0, 21'd0},
        '{ROW_LOAD, 8'h63, 6'd2,  1'b0, 1'b0, 1'b0, 21'd0},
        '{ROW_TEXT, 8'h61, 6'd0,  1'b0, 1'b0, 1'b0, 21'd0},
        '{ROW_TEXT, 8'h62, 6'd0,  1'b1, 1'b1, 1'b0, 21'd0},
        '{ROW_TEXT, 8'h61, 6'd0,  1'b0, 1'b0, 1'b0, 21'd0},
        '{ROW_TEXT, 8'h62, 6'd0,  1'b0, 1'b0, 1'b0, 21'd0},
        '{ROW_TEXT, 8'h63, 6'd0,  1'b1, 1'b1, 1'b1, 21'd1},
        '{ROW_CFG,  8'd0,  6'd0,  1'b0, 1'b0, 1'b0, 21'd0},
        '{ROW_TEXT, 8'h61, 6'd0,  1'b1, 1'b1, 1'b1, 21'd1}
    };

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver stalls
    always @(posedge clk)
    begin
        take_ok <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic int used_len();
        if (len_reg == 0)
            return 1;
        if (len_reg > PATTERN_MAX)
            return PATTERN_MAX;
        return int'(len_reg);
    endfunction

    // advance the search state by one accepted word, queue its result
    task automatic track_word(input logic req, input logic [BYTE_W-1:0] b,
                              input logic [IDX_W-1:0] ix, input logic lst,
                              input logic typed, input logic tf,
                              input logic [CNT_W-1:0] ts);
        int len;
        bit ok;
        bit got;
        match_res_t r;
        got = 1'b0;
        r = '0;
        if (req == pfms_pkg::REQ_LOAD)
        begin
            pat_store[ix] = b;
            return;
        end
        for (int k = PATTERN_MAX - 1; k > 0; k--)
            win[k] = win[k-1];
        win[0] = b;
        if (txt_count < TEXT_MAX)
            txt_count = txt_count + 1'b1;
        len = used_len();
        ok = 1'b1;
        if (txt_count < len)
            ok = 1'b0;
        else
            for (int j = 0; j < len; j++)
                if (win[len-1-j] !== pat_store[j])
                    ok = 1'b0;
        if (!hit_done && ok)
        begin
            hit_done = 1'b1;
            r.found = 1'b1;
            r.start = txt_count - CNT_W'(len) + 1'b1;
            got = 1'b1;
        end
        if (lst)
        begin
            // end of text with no match reported
            if (!got && !hit_done)
            begin
                r = '0;
                got = 1'b1;
            end
            for (int k = 0; k < PATTERN_MAX; k++)
                win[k] = '0;
            txt_count = '0;
            hit_done = 1'b0;
        end
        if (typed)
        begin
            r.found = tf;
            r.start = ts;
            pending_results = {pending_results, r};
        end
        else if (got)
            pending_results = {pending_results, r};
    endtask

    // present one word, hold it until taken
    task automatic put_word(input logic req, input logic [BYTE_W-1:0] b,
                            input logic [IDX_W-1:0] ix, input logic lst,
                            input logic typed = 1'b0, input logic tf = 1'b0,
                            input logic [CNT_W-1:0] ts = '0);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid         <= 1'b1;
        in_if.req_type      <= req;
        in_if.data_byte     <= b;
        in_if.pattern_index <= ix;
        in_if.last_byte     <= lst;
        @(posedge clk);
        while (!in_if.ready)
            @(posedge clk);
        words_taken++;
        track_word(req, b, ix, lst, typed, tf, ts);
    endtask

    // wait until the block has nothing left in flight
    task automatic settle();
        in_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_len(input logic [LEN_W-1:0] v);
        cfg_wen   <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_wen   <= 1'b0;
        len_reg = v;
    endtask

    function automatic logic [BYTE_W-1:0] pattern_letter();
        if ($urandom_range(99) < 80)
            return letters[$urandom_range(0, 2)];
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [BYTE_W-1:0] noise_byte();
        if ($urandom_range(99) < 50)
            return pat_store[$urandom_range(0, used_len() - 1)];
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    // one text: noise, mostly an embedded pattern copy, noise, last byte
    task automatic feed_text();
        logic [BYTE_W-1:0] txt [$];
        int len;
        int copies;
        int bad_at;
        len = used_len();
        repeat ($urandom_range(0, 6))
            txt = {txt, noise_byte()};
        if ($urandom_range(99) < 75)
        begin
            copies = ($urandom_range(99) < 20) ? 2 : 1;
            bad_at = ($urandom_range(99) < 25) ? $urandom_range(0, len - 1) : -1;
            repeat (copies)
                for (int j = 0; j < len; j++)
                    txt = {txt, (j == bad_at ? ~pat_store[j] : pat_store[j])};
        end
        else
            repeat ($urandom_range(1, len + 2))
                txt = {txt, noise_byte()};
        repeat ($urandom_range(0, 4))
            txt = {txt, noise_byte()};
        for (int k = 0; k < txt.size(); k++)
        begin
            // an occasional load word in the middle of a text
            if ($urandom_range(99) < 4)
                put_word(pfms_pkg::REQ_LOAD, BYTE_W'($urandom_range(0, 255)),
                         IDX_W'($urandom_range(0, PATTERN_MAX - 1)), 1'($urandom_range(0, 1)));
            put_word(pfms_pkg::REQ_TEXT, txt[k], IDX_W'($urandom_range(0, PATTERN_MAX - 1)),
                     k == txt.size() - 1);
        end
    endtask

    // result checker
    always @(posedge clk)
    begin : check_results
        match_res_t head;
        if (rst_n && out_if.valid && out_if.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: found=%0d match_start=%0d",
                       out_if.found, out_if.match_start);
                fail_count++;
            end
            else
            begin
                head = pending_results.pop_front();
                if (out_if.found !== head.found)
                begin
                    $error("found: expected %0d, got %0d", head.found, out_if.found);
                    fail_count++;
                end
                if (out_if.match_start !== head.start)
                begin
                    $error("match_start: expected %0d, got %0d",
                           head.start, out_if.match_start);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        dir_row_t row;
        int start_words;
        int len;
        logic [LEN_W-1:0] len_set;
        rst_n               = 1'b0;
        cfg_wen             = 1'b0;
        cfg_wdata           = '0;
        in_if.valid         = 1'b0;
        in_if.req_type      = pfms_pkg::REQ_LOAD;
        in_if.data_byte     = '0;
        in_if.pattern_index = '0;
        in_if.last_byte     = 1'b0;
        for (int k = 0; k < PATTERN_MAX; k++)
        begin
            pat_store[k] = '0;
            win[k]       = '0;
        end
        txt_count = '0;
        hit_done  = 1'b0;
        len_reg   = LEN_W'(1);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, starting at the default length after reset
        foreach (dir_tab[i])
        begin
            row = dir_tab[i];
            if (row.kind == ROW_CFG)
            begin
                settle();
                write_len(row.b[LEN_W-1:0]);
            end
            else
                put_word(row.kind == ROW_LOAD ? pfms_pkg::REQ_LOAD : pfms_pkg::REQ_TEXT,
                         row.b, row.ix, row.lst, row.typed, row.tf, row.ts);
        end

        // random phases over lengths and idle modes
        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle();
            case (ph)
                0: len_set = LEN_W'(PATTERN_MAX);
                1: len_set = LEN_W'(1);
                2: len_set = '1;
                3: len_set = '0;
                4: len_set = LEN_W'($urandom_range(2, 6));
                5: len_set = LEN_W'($urandom_range(PATTERN_MAX + 1, 126));
                6: len_set = LEN_W'($urandom_range(2, 12));
                default: len_set = LEN_W'($urandom_range(1, PATTERN_MAX));
            endcase
            write_len(len_set);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
                1: begin send_idle_pct = 65; recv_stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct <= 65; end
                default: begin send_idle_pct = 24; recv_stall_pct <= 24; end
            endcase
            for (int k = 0; k < 3; k++)
                letters[k] = BYTE_W'($urandom_range(0, 255));
            len = used_len();
            start_words = words_taken;
            for (int j = 0; j < len; j++)
                put_word(pfms_pkg::REQ_LOAD, pattern_letter(), IDX_W'(j),
                         1'($urandom_range(0, 1)));
            while (words_taken - start_words < PHASE_WORDS)
            begin
                feed_text();
                // rewrite a few pattern bytes between texts
                if ($urandom_range(99) < 20)
                    repeat ($urandom_range(1, 3))
                        put_word(pfms_pkg::REQ_LOAD, pattern_letter(),
                                 IDX_W'($urandom_range(0, len - 1)), 1'b0);
            end
        end

        settle();
        if (fail_count == 0 && pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
